// ===== rtl/fjop_pkg.sv =====
// Shared types, character constants and helpers for the flat JSON object parser.
package fjop_pkg;

    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_RBRACE = 8'h7D;
    localparam logic [7:0] C_COLON  = 8'h3A;
    localparam logic [7:0] C_COMMA  = 8'h2C;
    localparam logic [7:0] C_QUOTE  = 8'h22;
    localparam logic [7:0] C_BSLASH = 8'h5C;
    localparam logic [7:0] C_SLASH  = 8'h2F;
    localparam logic [7:0] C_BS     = 8'h08;
    localparam logic [7:0] C_FF     = 8'h0C;
    localparam logic [7:0] C_LF     = 8'h0A;
    localparam logic [7:0] C_CR     = 8'h0D;
    localparam logic [7:0] C_TAB    = 8'h09;
    localparam logic [7:0] C_VT     = 8'h0B;
    localparam logic [7:0] C_SPACE  = 8'h20;
    localparam logic [7:0] C_LOW_B  = 8'h62;
    localparam logic [7:0] C_LOW_F  = 8'h66;
    localparam logic [7:0] C_LOW_N  = 8'h6E;
    localparam logic [7:0] C_LOW_R  = 8'h72;
    localparam logic [7:0] C_LOW_T  = 8'h74;

    localparam int KIND_W = 3;

    typedef enum logic [KIND_W-1:0] {
        EK_NONE   = 3'd0,
        EK_KEY    = 3'd1,
        EK_VALUE  = 3'd2,
        EK_KCLOSE = 3'd3,
        EK_PCLOSE = 3'd4
    } t_kind;

    typedef enum logic [10:0] {
        PH_OPEN       = 11'b000_0000_0001,
        PH_AFTER_OPEN = 11'b000_0000_0010,
        PH_KEY        = 11'b000_0000_0100,
        PH_KEY_ESC    = 11'b000_0000_1000,
        PH_COLON      = 11'b000_0001_0000,
        PH_VAL_START  = 11'b000_0010_0000,
        PH_VAL        = 11'b000_0100_0000,
        PH_VAL_ESC    = 11'b000_1000_0000,
        PH_AFTER_VAL  = 11'b001_0000_0000,
        PH_NEXT_KEY   = 11'b010_0000_0000,
        PH_DONE       = 11'b100_0000_0000
    } t_phase;

    typedef struct packed {
        logic       ok;
        logic [7:0] dec;
    } t_esc;

    typedef struct packed {
        t_phase     phase;
        logic       err;
        t_kind      kind;
        logic [7:0] ob;
        logic       failed;
        logic       object_ok;
    } t_step;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == C_SPACE) || ((c >= C_TAB) && (c <= C_CR));
    endfunction

    function automatic t_esc decode_escape(input logic [7:0] c);
        t_esc e;
        e.ok  = 1'b1;
        e.dec = 8'h00;
        unique case (c)
            C_QUOTE, C_BSLASH, C_SLASH: e.dec = c;
            C_LOW_B: e.dec = C_BS;
            C_LOW_F: e.dec = C_FF;
            C_LOW_N: e.dec = C_LF;
            C_LOW_R: e.dec = C_CR;
            C_LOW_T: e.dec = C_TAB;
            default: e.ok  = 1'b0;
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/fjop_step.sv =====
// Next-state and result logic for one byte of the parser.
module fjop_step (
    input  fjop_pkg::t_phase i_phase,
    input  logic             i_err,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output fjop_pkg::t_step  o_res
);

    fjop_pkg::t_phase ph;
    fjop_pkg::t_kind  kind;
    fjop_pkg::t_esc   esc;
    logic [7:0]       ob;
    logic             bad;
    logic             err;
    logic             ws;
    logic             ok;

    always_comb begin
        ph   = i_phase;
        kind = fjop_pkg::EK_NONE;
        ob   = 8'h00;
        bad  = 1'b0;
        ws   = fjop_pkg::is_ws(i_byte);
        esc  = fjop_pkg::decode_escape(i_byte);
        if (!i_err) begin
            unique case (i_phase)
                fjop_pkg::PH_OPEN: begin
                    if (i_byte == fjop_pkg::C_LBRACE) ph = fjop_pkg::PH_AFTER_OPEN;
                    else if (!ws) bad = 1'b1;
                end
                fjop_pkg::PH_AFTER_OPEN: begin
                    if (i_byte == fjop_pkg::C_RBRACE) ph = fjop_pkg::PH_DONE;
                    else if (i_byte == fjop_pkg::C_QUOTE) ph = fjop_pkg::PH_KEY;
                    else if (!ws) bad = 1'b1;
                end
                fjop_pkg::PH_NEXT_KEY: begin
                    if (i_byte == fjop_pkg::C_QUOTE) ph = fjop_pkg::PH_KEY;
                    else if (!ws) bad = 1'b1;
                end
                fjop_pkg::PH_KEY: begin
                    if (i_byte == fjop_pkg::C_QUOTE) begin
                        kind = fjop_pkg::EK_KCLOSE;
                        ph   = fjop_pkg::PH_COLON;
                    end else if (i_byte == fjop_pkg::C_BSLASH) begin
                        ph = fjop_pkg::PH_KEY_ESC;
                    end else begin
                        kind = fjop_pkg::EK_KEY;
                        ob   = i_byte;
                    end
                end
                fjop_pkg::PH_VAL: begin
                    if (i_byte == fjop_pkg::C_QUOTE) begin
                        kind = fjop_pkg::EK_PCLOSE;
                        ph   = fjop_pkg::PH_AFTER_VAL;
                    end else if (i_byte == fjop_pkg::C_BSLASH) begin
                        ph = fjop_pkg::PH_VAL_ESC;
                    end else begin
                        kind = fjop_pkg::EK_VALUE;
                        ob   = i_byte;
                    end
                end
                fjop_pkg::PH_KEY_ESC: begin
                    if (esc.ok) begin
                        kind = fjop_pkg::EK_KEY;
                        ob   = esc.dec;
                        ph   = fjop_pkg::PH_KEY;
                    end else begin
                        bad = 1'b1;
                    end
                end
                fjop_pkg::PH_VAL_ESC: begin
                    if (esc.ok) begin
                        kind = fjop_pkg::EK_VALUE;
                        ob   = esc.dec;
                        ph   = fjop_pkg::PH_VAL;
                    end else begin
                        bad = 1'b1;
                    end
                end
                fjop_pkg::PH_COLON: begin
                    if (i_byte == fjop_pkg::C_COLON) ph = fjop_pkg::PH_VAL_START;
                    else if (!ws) bad = 1'b1;
                end
                fjop_pkg::PH_VAL_START: begin
                    if (i_byte == fjop_pkg::C_QUOTE) ph = fjop_pkg::PH_VAL;
                    else if (!ws) bad = 1'b1;
                end
                fjop_pkg::PH_AFTER_VAL: begin
                    if (i_byte == fjop_pkg::C_RBRACE) ph = fjop_pkg::PH_DONE;
                    else if (i_byte == fjop_pkg::C_COMMA) ph = fjop_pkg::PH_NEXT_KEY;
                    else if (!ws) bad = 1'b1;
                end
                fjop_pkg::PH_DONE: begin
                    if (!ws) bad = 1'b1;
                end
                default: bad = 1'b1;
            endcase
            if (bad) begin
                kind = fjop_pkg::EK_NONE;
                ob   = 8'h00;
            end
        end
        err = i_err | bad;
        ok  = 1'b0;
        if (i_last) begin
            ok  = !err && (ph == fjop_pkg::PH_DONE);
            err = err | !ok;
        end

        o_res.kind      = kind;
        o_res.ob        = ob;
        o_res.failed    = err;
        o_res.object_ok = ok;
        // end of text: back to the start state
        o_res.phase     = i_last ? fjop_pkg::PH_OPEN : ph;
        o_res.err       = i_last ? 1'b0 : err;
    end

endmodule

// ===== rtl/flat_json_object_parser.sv =====
// Top level: input register, parse state and result register of the JSON object parser.
// Throughput: one byte per cycle while m_axis_tready does not stall the result register;
// the parse state updates in the same cycle as the result register loads.
// Stalls: a full input stage is held while the result register waits on m_axis_tready.
// Reset: synchronous, active low; clears valid flags, phase to expect-open-brace, error flag.
module flat_json_object_parser (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] out_byte, [8] failed, [9] object_ok, rest zero
    output logic [2:0] m_axis_tuser    // [2:0] emit_kind
);

    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    fjop_pkg::t_phase r_phase;
    logic             r_err;
    logic             r_out_valid;
    fjop_pkg::t_kind  r_kind;
    logic [7:0]       r_ob;
    logic             r_failed;
    logic             r_ok;

    fjop_pkg::t_step  n_step;
    logic             advance;

    fjop_step u_step (
        .i_phase (r_phase),
        .i_err   (r_err),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_res   (n_step)
    );

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= fjop_pkg::PH_OPEN;
            r_err       <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_phase <= n_step.phase;
                    r_err   <= n_step.err;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        if (advance && r_in_valid) begin
            r_kind   <= n_step.kind;
            r_ob     <= n_step.ob;
            r_failed <= n_step.failed;
            r_ok     <= n_step.object_ok;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_ok, r_failed, r_ob};
    assign m_axis_tuser  = r_kind;

endmodule

// ===== rtl/fjop_checker.sv =====
// Port-level checker for the JSON object parser, bound to the top level.
module fjop_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    logic [1:0] r_cnt;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // items accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= r_cnt + {1'b0, in_acc} - {1'b0, out_acc};
        end
    end

    a_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt <= 2'd2) && (!m_axis_tvalid || r_cnt != 2'd0))
        else $error("items in flight out of range");

    a_ok_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[9]) |-> !m_axis_tdata[8])
        else $error("object_ok with failed set");

    // a string byte or closing quote never completes the object, and its kind is in range
    a_emit_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != fjop_pkg::EK_NONE) |->
        (!m_axis_tdata[9] && m_axis_tuser <= fjop_pkg::EK_PCLOSE))
        else $error("emission with object_ok or bad kind");

    a_byte_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[7:0] != 8'h00) |->
        (m_axis_tuser == fjop_pkg::EK_KEY || m_axis_tuser == fjop_pkg::EK_VALUE))
        else $error("out_byte set without key or value kind");

endmodule

bind flat_json_object_parser fjop_checker u_fjop_checker (.*);

// ===== tb/flat_json_checker.sv =====
// Stream monitor, parse predictor and result comparison for the flat JSON object parser.
`timescale 1ns / 1ps

module flat_json_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_in_data,    // [7:0] in_byte
    input  logic        i_in_last,    // last_byte
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [15:0] i_out_data,   // [7:0] out_byte, [8] failed, [9] object_ok
    input  logic [2:0]  i_out_kind,   // [2:0] emit_kind
    output int          o_failures,
    output int          o_pending,
    output int          o_results,
    output int          o_texts,
    output int          o_good_texts
);

    typedef struct packed {
        fjop_pkg::t_kind kind;
        logic [7:0]      ch;
        logic            failed;
        logic            ok;
    } t_outcome;

    t_outcome         pending_results[$];
    fjop_pkg::t_phase parse_at;
    logic             broken;
    int               mismatches;
    int               n_results;
    int               n_texts;
    int               n_good;

    function automatic logic json_space(input logic [7:0] c);
        return c == fjop_pkg::C_SPACE || c == fjop_pkg::C_TAB || c == fjop_pkg::C_LF ||
               c == fjop_pkg::C_VT || c == fjop_pkg::C_FF || c == fjop_pkg::C_CR;
    endfunction

    task automatic advance_parser(input logic [7:0] c, input logic fin, output t_outcome res);
        logic       bad;
        logic       esc_ok;
        logic [7:0] esc_ch;
        res = '{kind: fjop_pkg::EK_NONE, ch: 8'h00, failed: 1'b0, ok: 1'b0};
        bad = 1'b0;
        if (!broken) begin
            case (parse_at)
                fjop_pkg::PH_OPEN: begin
                    if (c == fjop_pkg::C_LBRACE) parse_at = fjop_pkg::PH_AFTER_OPEN;
                    else if (!json_space(c)) bad = 1'b1;
                end
                fjop_pkg::PH_AFTER_OPEN: begin
                    if (c == fjop_pkg::C_RBRACE) parse_at = fjop_pkg::PH_DONE;
                    else if (c == fjop_pkg::C_QUOTE) parse_at = fjop_pkg::PH_KEY;
                    else if (!json_space(c)) bad = 1'b1;
                end
                fjop_pkg::PH_NEXT_KEY: begin
                    if (c == fjop_pkg::C_QUOTE) parse_at = fjop_pkg::PH_KEY;
                    else if (!json_space(c)) bad = 1'b1;
                end
                fjop_pkg::PH_KEY, fjop_pkg::PH_VAL: begin
                    if (c == fjop_pkg::C_QUOTE) begin
                        res.kind = (parse_at == fjop_pkg::PH_KEY) ?
                                   fjop_pkg::EK_KCLOSE : fjop_pkg::EK_PCLOSE;
                        parse_at = (parse_at == fjop_pkg::PH_KEY) ?
                                   fjop_pkg::PH_COLON : fjop_pkg::PH_AFTER_VAL;
                    end else if (c == fjop_pkg::C_BSLASH) begin
                        parse_at = (parse_at == fjop_pkg::PH_KEY) ?
                                   fjop_pkg::PH_KEY_ESC : fjop_pkg::PH_VAL_ESC;
                    end else begin
                        res.kind = (parse_at == fjop_pkg::PH_KEY) ?
                                   fjop_pkg::EK_KEY : fjop_pkg::EK_VALUE;
                        res.ch   = c;
                    end
                end
                fjop_pkg::PH_KEY_ESC, fjop_pkg::PH_VAL_ESC: begin
                    esc_ok = 1'b1;
                    esc_ch = 8'h00;
                    case (c)
                        fjop_pkg::C_QUOTE, fjop_pkg::C_BSLASH, fjop_pkg::C_SLASH: esc_ch = c;
                        fjop_pkg::C_LOW_B: esc_ch = fjop_pkg::C_BS;
                        fjop_pkg::C_LOW_F: esc_ch = fjop_pkg::C_FF;
                        fjop_pkg::C_LOW_N: esc_ch = fjop_pkg::C_LF;
                        fjop_pkg::C_LOW_R: esc_ch = fjop_pkg::C_CR;
                        fjop_pkg::C_LOW_T: esc_ch = fjop_pkg::C_TAB;
                        default: esc_ok = 1'b0;
                    endcase
                    if (esc_ok) begin
                        res.kind = (parse_at == fjop_pkg::PH_KEY_ESC) ?
                                   fjop_pkg::EK_KEY : fjop_pkg::EK_VALUE;
                        res.ch   = esc_ch;
                        parse_at = (parse_at == fjop_pkg::PH_KEY_ESC) ?
                                   fjop_pkg::PH_KEY : fjop_pkg::PH_VAL;
                    end else begin
                        bad = 1'b1;
                    end
                end
                fjop_pkg::PH_COLON: begin
                    if (c == fjop_pkg::C_COLON) parse_at = fjop_pkg::PH_VAL_START;
                    else if (!json_space(c)) bad = 1'b1;
                end
                fjop_pkg::PH_VAL_START: begin
                    if (c == fjop_pkg::C_QUOTE) parse_at = fjop_pkg::PH_VAL;
                    else if (!json_space(c)) bad = 1'b1;
                end
                fjop_pkg::PH_AFTER_VAL: begin
                    if (c == fjop_pkg::C_RBRACE) parse_at = fjop_pkg::PH_DONE;
                    else if (c == fjop_pkg::C_COMMA) parse_at = fjop_pkg::PH_NEXT_KEY;
                    else if (!json_space(c)) bad = 1'b1;
                end
                fjop_pkg::PH_DONE: begin
                    if (!json_space(c)) bad = 1'b1;
                end
                default: bad = 1'b1;
            endcase
            if (bad) begin
                broken   = 1'b1;
                res.kind = fjop_pkg::EK_NONE;
                res.ch   = 8'h00;
            end
        end
        if (fin) begin
            res.ok = !broken && parse_at == fjop_pkg::PH_DONE;
            if (!res.ok) broken = 1'b1;
        end
        res.failed = broken;
        if (fin) begin
            parse_at = fjop_pkg::PH_OPEN;
            broken   = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (!i_rst_n) begin
            pending_results.delete();
            parse_at   = fjop_pkg::PH_OPEN;
            broken     = 1'b0;
            mismatches = 0;
            n_results  = 0;
            n_texts    = 0;
            n_good     = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                n_results++;
                got = '{kind: fjop_pkg::t_kind'(i_out_kind), ch: i_out_data[7:0],
                        failed: i_out_data[8], ok: i_out_data[9]};
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] result with nothing outstanding: kind %0d byte %02h",
                                 $realtime, i_out_kind, i_out_data[7:0]);
                end else begin
                    want = pending_results.pop_front();
                    if (got.kind !== want.kind || got.ch !== want.ch ||
                        got.failed !== want.failed || got.ok !== want.ok ||
                        i_out_data[15:10] !== 6'd0) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] result %0d: want kind/byte/failed/ok %0d/%02h/%0b/%0b, got %0d/%02h/%0b/%0b pad %02h",
                                     $realtime, n_results, want.kind, want.ch, want.failed,
                                     want.ok, i_out_kind, i_out_data[7:0], i_out_data[8],
                                     i_out_data[9], i_out_data[15:10]);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                advance_parser(i_in_data, i_in_last, want);
                pending_results = {pending_results, want};
                if (i_in_last) begin
                    n_texts++;
                    if (want.ok) n_good++;
                end
            end
        end
        o_failures   <= mismatches;
        o_pending    <= pending_results.size();
        o_results    <= n_results;
        o_texts      <= n_texts;
        o_good_texts <= n_good;
    end

endmodule

// ===== tb/tb_flat_json_object_parser.sv =====
// Top of the parser testbench: clock, reset, byte stimulus, output back-pressure and verdict.
`timescale 1ns / 1ps

module tb_flat_json_object_parser;

    localparam int N_ITEMS      = 1500;
    localparam int LIMIT_CYCLES = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] in_byte
    logic        s_axis_tlast = 1'b0;    // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] out_byte, [8] failed, [9] object_ok
    logic [2:0]  m_axis_tuser;           // [2:0] emit_kind

    int          failures;
    int          pending;
    int          results;
    int          texts;
    int          good_texts;
    int          bytes_sent = 0;
    int          cycle_count = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;
    logic [7:0]  text_q[$];

    always #5 i_clk = ~i_clk;

    flat_json_object_parser i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    flat_json_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_in_last    (s_axis_tlast),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .i_out_kind   (m_axis_tuser),
        .o_failures   (failures),
        .o_pending    (pending),
        .o_results    (results),
        .o_texts      (texts),
        .o_good_texts (good_texts)
    );

    // mostly short pauses, now and then a long one
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_space();
        case ($urandom_range(0, 5))
            0: return fjop_pkg::C_SPACE;
            1: return fjop_pkg::C_TAB;
            2: return fjop_pkg::C_LF;
            3: return fjop_pkg::C_VT;
            4: return fjop_pkg::C_FF;
            default: return fjop_pkg::C_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_escape();
        case ($urandom_range(0, 7))
            0: return fjop_pkg::C_QUOTE;
            1: return fjop_pkg::C_BSLASH;
            2: return fjop_pkg::C_SLASH;
            3: return fjop_pkg::C_LOW_B;
            4: return fjop_pkg::C_LOW_F;
            5: return fjop_pkg::C_LOW_N;
            6: return fjop_pkg::C_LOW_R;
            default: return fjop_pkg::C_LOW_T;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 99) < 20) begin
            m_axis_tready <= 1'b0;
            stall_left    <= pause_len() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, pending);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] b, input logic fin);
        if (!quiet && $urandom_range(0, 99) < 25) begin
            s_axis_tvalid <= 1'b0;
            repeat (pause_len()) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= fin;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
    endtask

    task automatic send_text();
        int n;
        n = text_q.size();
        for (int i = 0; i < n; i++) send_item(text_q[i], i == n - 1);
        text_q.delete();
    endtask

    task automatic append_byte(input logic [7:0] b);
        text_q = {text_q, b};
    endtask

    task automatic queue_str(input string s);
        for (int i = 0; i < s.len(); i++) append_byte(s[i]);
    endtask

    task automatic add_space(input int most);
        repeat ($urandom_range(0, most)) append_byte(pick_space());
    endtask

    task automatic add_string();
        int         r;
        logic [7:0] c;
        append_byte(fjop_pkg::C_QUOTE);
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                append_byte(fjop_pkg::C_BSLASH);
                append_byte(pick_escape());
            end else if (r < 18) begin
                append_byte(fjop_pkg::C_BSLASH);
                append_byte(8'($urandom_range(0, 255)));
            end else begin
                do c = 8'($urandom_range(0, 255));
                while (c == fjop_pkg::C_QUOTE || c == fjop_pkg::C_BSLASH);
                append_byte(c);
            end
        end
        append_byte(fjop_pkg::C_QUOTE);
    endtask

    task automatic build_object();
        int n_pairs;
        int r;
        n_pairs = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 3);
        add_space(2);
        append_byte(fjop_pkg::C_LBRACE);
        add_space(1);
        for (int p = 0; p < n_pairs; p++) begin
            add_string();
            add_space(1);
            append_byte(fjop_pkg::C_COLON);
            add_space(1);
            add_string();
            add_space(1);
            if (p != n_pairs - 1) begin
                append_byte(fjop_pkg::C_COMMA);
                add_space(1);
            end
        end
        append_byte(fjop_pkg::C_RBRACE);
        add_space(2);
        // a share of the objects gets one byte overwritten at random or is cut short
        r = $urandom_range(0, 99);
        if (r < 12)
            text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
        else if (r < 20)
            text_q = text_q[0:$urandom_range(0, text_q.size() - 1)];
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 10)) begin
            case ($urandom_range(0, 7))
                0: append_byte(fjop_pkg::C_LBRACE);
                1: append_byte(fjop_pkg::C_RBRACE);
                2: append_byte(fjop_pkg::C_QUOTE);
                3: append_byte(fjop_pkg::C_COLON);
                4: append_byte(fjop_pkg::C_COMMA);
                5: append_byte(pick_space());
                default: append_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty object
        queue_str("{}");
        send_text();
        // byte extremes in key and value, escapes, leading space
        queue_str(" {\"");
        append_byte(8'h00);
        queue_str("\\b\":\"");
        append_byte(8'hFF);
        queue_str("\\t\"}");
        send_text();
        // escape that is not allowed
        queue_str("{\"\\u");
        send_text();
        // wrong byte, then bytes that follow it
        queue_str("{x}");
        send_text();
        // text ends before the closing brace
        queue_str("{\"a\"");
        send_text();

        while (bytes_sent < N_ITEMS) begin
            quiet = ($urandom_range(0, 9) == 0);
            if ($urandom_range(0, 99) < 80) build_object();
            else build_noise();
            send_text();
        end
        quiet = 1'b0;

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d bytes in %0d texts, %0d of them valid objects; %0d results checked.",
                 bytes_sent, texts, good_texts, results);
        if (failures == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches, %0d results outstanding", failures, pending);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== flat_json_object_parser.f =====
rtl/fjop_pkg.sv
rtl/fjop_step.sv
rtl/flat_json_object_parser.sv
rtl/fjop_checker.sv
tb/flat_json_checker.sv
tb/tb_flat_json_object_parser.sv
